>>> hdl/wmfc_pkg.sv
package wmfc_pkg;

  localparam int DEPTH   = 256;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LEVEL_W = $clog2(DEPTH + 1);
  localparam int LIMIT_W = 9;
  localparam int FILL_W  = 9;
  localparam int BYTE_W  = 8;
  localparam int CMP_W   = (LEVEL_W > LIMIT_W) ? LEVEL_W : LIMIT_W;

  localparam logic [LIMIT_W-1:0] STOP_LIMIT_RST   = LIMIT_W'(192);
  localparam logic [LIMIT_W-1:0] RESUME_LIMIT_RST = LIMIT_W'(64);

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_READ     = 2'd1,
    CMD_GO_ACK   = 2'd2,
    CMD_STOP_ACK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FS_GO       = 2'd0,
    FS_STOPPING = 2'd1,
    FS_STOP     = 2'd2,
    FS_RESUMING = 2'd3
  } flow_state_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_GO   = 2'd1,
    ACT_STOP = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_FULL  = 2'd1,
    FLT_EMPTY = 2'd2
  } fault_t;

  typedef enum logic {
    REG_STOP_LIMIT   = 1'b0,
    REG_RESUME_LIMIT = 1'b1
  } reg_index_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
    logic load_out;
  } dp_cmd_t;

endpackage

>>> hdl/watermark_flow_control_fifo.sv
// Channel   Direction  tdata (low bit up)                          tuser
// s_axis    in         write_byte[7:0]                             cmd[1:0]
// m_axis    out        read_byte, action, fault, fill_level, pad   read_valid
// cfg       in         cfg_data: stop_limit / resume_limit by cfg_addr
//
// Each request is accepted in the idle state, and the registered byte store read
// completes in the exec state, after which the result enters the output register.
// A request is taken while an earlier result still waits in the output register.
// A stalled m_axis holds the following request in the exec state.
// rst is synchronous: level 0, both pointers 0, flow state go, limits 192/64.
module watermark_flow_control_fifo
  import wmfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // write_byte[7:0]
  input  logic [1:0]         s_tuser,   // cmd[1:0]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,   // read_byte[7:0], action[9:8], fault[11:10],
                                        // fill_level[20:12], zero[23:21]
  output logic               m_tuser,   // read_valid
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [LIMIT_W-1:0] cfg_data
);

  dp_cmd_t           cmd;
  logic [BYTE_W-1:0] read_byte;
  logic [1:0]        action;
  logic [1:0]        fault;
  logic [FILL_W-1:0] fill_level;

  wmfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  wmfc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_cmd     (s_tuser),
    .in_byte    (s_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .read_byte  (read_byte),
    .read_valid (m_tuser),
    .action     (action),
    .fault      (fault),
    .fill_level (fill_level)
  );

  assign m_tdata = {3'b000, fill_level, fault, action, read_byte};

endmodule

>>> hdl/wmfc_ram.sv
module wmfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/wmfc_ctrl.sv
module wmfc_ctrl
  import wmfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (in_valid) begin
          state_next = CS_EXEC;
        end
      end
      CS_EXEC: begin
        if (!out_valid || out_ready) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
      end
      CS_EXEC: begin
        // hold the result until the output register frees up
        cmd.load_out = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  assign out_valid_next = cmd.load_out || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> hdl/wmfc_dp.sv
module wmfc_dp
  import wmfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [1:0]         in_cmd,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [LIMIT_W-1:0] cfg_data,
  output logic [BYTE_W-1:0]  read_byte,
  output logic               read_valid,
  output logic [1:0]         action,
  output logic [1:0]         fault,
  output logic [FILL_W-1:0]  fill_level
);

  logic [ADDR_W-1:0]  head, head_next;
  logic [ADDR_W-1:0]  tail, tail_next;
  logic [LEVEL_W-1:0] occupancy, occupancy_next;
  flow_state_t        flow, flow_mid, flow_next;
  logic [LIMIT_W-1:0] stop_limit, resume_limit;
  action_t            pend_action, action_next;
  fault_t             pend_fault, fault_next;
  logic               pend_rvalid, rvalid_next;
  logic               ram_we;
  logic [BYTE_W-1:0]  ram_rdata;
  logic               full, empty;
  logic [CMP_W-1:0]   level_cmp, stop_cmp, resume_cmp;

  wmfc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (in_byte),
    .re    (cmd.exec),
    .raddr (head),
    .rdata (ram_rdata)
  );

  function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx);
    advance = (idx == ADDR_W'(DEPTH - 1)) ? '0 : idx + ADDR_W'(1);
  endfunction

  assign full  = (occupancy == LEVEL_W'(DEPTH));
  assign empty = (occupancy == '0);

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    occupancy_next = occupancy;
    flow_mid       = flow;
    fault_next     = FLT_NONE;
    rvalid_next    = 1'b0;
    ram_we         = 1'b0;
    case (cmd_t'(in_cmd))
      CMD_WRITE: begin
        if (full) begin
          fault_next = FLT_FULL;
        end else begin
          ram_we         = cmd.exec;
          tail_next      = advance(tail);
          occupancy_next = occupancy + LEVEL_W'(1);
        end
      end
      CMD_READ: begin
        if (empty) begin
          fault_next = FLT_EMPTY;
        end else begin
          rvalid_next    = 1'b1;
          head_next      = advance(head);
          occupancy_next = occupancy - LEVEL_W'(1);
        end
      end
      CMD_GO_ACK: begin
        if (flow == FS_RESUMING) begin
          flow_mid = FS_GO;
        end
      end
      default: begin
        if (flow == FS_STOPPING) begin
          flow_mid = FS_STOP;
        end
      end
    endcase
  end

  assign level_cmp  = CMP_W'(occupancy_next);
  assign stop_cmp   = CMP_W'(stop_limit);
  assign resume_cmp = CMP_W'(resume_limit);

  // watermark check on the level left by this request
  always_comb begin
    flow_next   = flow_mid;
    action_next = ACT_NONE;
    if (flow_mid == FS_GO && level_cmp > stop_cmp) begin
      flow_next   = FS_STOPPING;
      action_next = ACT_STOP;
    end else if (flow_mid == FS_STOP && level_cmp <= resume_cmp) begin
      flow_next   = FS_RESUMING;
      action_next = ACT_GO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head         <= '0;
      tail         <= '0;
      occupancy    <= '0;
      flow         <= FS_GO;
      stop_limit   <= STOP_LIMIT_RST;
      resume_limit <= RESUME_LIMIT_RST;
    end else begin
      if (cmd.exec) begin
        head      <= head_next;
        tail      <= tail_next;
        occupancy <= occupancy_next;
        flow      <= flow_next;
      end
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_addr))
          REG_STOP_LIMIT:   stop_limit   <= cfg_data;
          REG_RESUME_LIMIT: resume_limit <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pend_action <= action_next;
      pend_fault  <= fault_next;
      pend_rvalid <= rvalid_next;
    end
    if (cmd.load_out) begin
      read_byte  <= pend_rvalid ? ram_rdata : '0;
      read_valid <= pend_rvalid;
      action     <= pend_action;
      fault      <= pend_fault;
      fill_level <= FILL_W'(occupancy);
    end
  end

endmodule

>>> test/watermark_flow_control_fifo_tb.sv
import wmfc_pkg::*;

typedef struct {
  logic [BYTE_W-1:0] rbyte;
  logic              rvalid;
  action_t           act;
  fault_t            flt;
  logic [FILL_W-1:0] level;
} fifo_result_t;

class watermark_scoreboard;
  logic [BYTE_W-1:0]  stored [DEPTH];
  int unsigned        rd_ptr;
  int unsigned        wr_ptr;
  int unsigned        held;
  flow_state_t        flow;
  logic [LIMIT_W-1:0] stop_lim;
  logic [LIMIT_W-1:0] resume_lim;
  fifo_result_t       pending_results[$];
  int unsigned        mismatches;

  function new();
    rd_ptr     = 0;
    wr_ptr     = 0;
    held       = 0;
    flow       = FS_GO;
    stop_lim   = STOP_LIMIT_RST;
    resume_lim = RESUME_LIMIT_RST;
    mismatches = 0;
  endfunction

  function void set_limit(reg_index_t idx, logic [LIMIT_W-1:0] value);
    if (idx == REG_STOP_LIMIT) begin
      stop_lim = value;
    end else begin
      resume_lim = value;
    end
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction

  // Advance the FIFO and flow state by one accepted request.
  function void note_request(cmd_t c, logic [BYTE_W-1:0] b);
    fifo_result_t r;
    r.rbyte  = '0;
    r.rvalid = 1'b0;
    r.act    = ACT_NONE;
    r.flt    = FLT_NONE;
    case (c)
      CMD_WRITE: begin
        if (held >= DEPTH) begin
          r.flt = FLT_FULL;
        end else begin
          stored[wr_ptr] = b;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          held++;
        end
      end
      CMD_READ: begin
        if (held == 0) begin
          r.flt = FLT_EMPTY;
        end else begin
          r.rbyte  = stored[rd_ptr];
          r.rvalid = 1'b1;
          rd_ptr   = (rd_ptr + 1) % DEPTH;
          held--;
        end
      end
      CMD_GO_ACK: begin
        if (flow == FS_RESUMING) flow = FS_GO;
      end
      default: begin
        if (flow == FS_STOPPING) flow = FS_STOP;
      end
    endcase
    // hysteresis check runs after every request, acknowledgements included
    if (flow == FS_GO && held > stop_lim) begin
      flow  = FS_STOPPING;
      r.act = ACT_STOP;
    end else if (flow == FS_STOP && held <= resume_lim) begin
      flow  = FS_RESUMING;
      r.act = ACT_GO;
    end
    r.level = FILL_W'(held);
    pending_results.push_back(r);
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function void check_result(logic [23:0] data, logic rv);
    fifo_result_t e;
    if (pending_results.size() == 0) begin
      flag($sformatf("unexpected result: data %06h read_valid %0b", data, rv));
      return;
    end
    e = pending_results.pop_front();
    if (data[7:0] !== e.rbyte || rv !== e.rvalid || data[9:8] !== e.act ||
        data[11:10] !== e.flt || data[20:12] !== e.level || data[23:21] !== 3'b000) begin
      flag($sformatf({"result mismatch: expected byte %02h valid %0b action %0d fault %0d",
                      " level %0d, got byte %02h valid %0b action %0d fault %0d level %0d",
                      " pad %0h"},
                     e.rbyte, e.rvalid, e.act, e.flt, e.level,
                     data[7:0], rv, data[9:8], data[11:10], data[20:12], data[23:21]));
    end
  endfunction
endclass

module watermark_flow_control_fifo_tb;

  logic               clk      = 1'b0;
  logic               rst      = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata  = '0;
  logic [1:0]         s_tuser  = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [23:0]        m_tdata;
  logic               m_tuser;
  logic               cfg_we   = 1'b0;
  logic               cfg_addr = 1'b0;
  logic [LIMIT_W-1:0] cfg_data = '0;

  watermark_scoreboard sb = new();
  bit                  sender_eager = 1'b0;

  int unsigned phase_len [6] = '{350, 350, 300, 300, 300, 250};
  int unsigned phase_wr  [6] = '{80, 8, 44, 80, 8, 44};
  int unsigned phase_rd  [6] = '{8, 80, 44, 8, 80, 44};
  int unsigned phase_stop[6] = '{200, 256, 0, 0, 255, 128};
  int unsigned phase_res [6] = '{40, 0, 0, 256, 255, 127};

  watermark_flow_control_fifo i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_request(input cmd_t c, input logic [7:0] b);
    int unsigned gap;
    gap = sender_eager ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= c;
    do @(posedge clk); while (!s_tready);
    sb.note_request(c, b);
  endtask

  // Hold the sender off until every outstanding request has its result.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_limits(input logic [LIMIT_W-1:0] stop_v,
                              input logic [LIMIT_W-1:0] resume_v);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_STOP_LIMIT;
    cfg_data <= stop_v;
    sb.set_limit(REG_STOP_LIMIT, stop_v);
    @(negedge clk);
    cfg_addr <= REG_RESUME_LIMIT;
    cfg_data <= resume_v;
    sb.set_limit(REG_RESUME_LIMIT, resume_v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned wr_pct,
                           input int unsigned rd_pct);
    int unsigned roll;
    cmd_t        c;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < wr_pct) begin
        c = CMD_WRITE;
      end else if (roll < wr_pct + rd_pct) begin
        c = CMD_READ;
      end else if (sb.flow == FS_STOPPING && $urandom_range(0, 3) != 0) begin
        c = CMD_STOP_ACK;
      end else if (sb.flow == FS_RESUMING && $urandom_range(0, 3) != 0) begin
        c = CMD_GO_ACK;
      end else begin
        c = $urandom_range(0, 1) ? CMD_GO_ACK : CMD_STOP_ACK;
      end
      send_request(c, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    wait (rst === 1'b0);
    forever begin
      // long hold-offs let the block fill and back-pressure the sender
      if (taken == 400 || taken == 1500) begin
        stall = 80;
      end else if ((taken / 150) % 3 == 1) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 5);
      end
      @(negedge clk);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata, m_tuser);
      taken++;
    end
  end

  initial begin : request_source
    logic [LIMIT_W-1:0] stop_v;
    logic [LIMIT_W-1:0] resume_v;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset limits: empty read, extreme bytes, stray acknowledgements
    send_request(CMD_READ, 8'h00);
    send_request(CMD_WRITE, 8'h00);
    send_request(CMD_WRITE, 8'hFF);
    send_request(CMD_WRITE, 8'hA5);
    send_request(CMD_GO_ACK, 8'h00);
    send_request(CMD_STOP_ACK, 8'hFF);
    send_request(CMD_READ, 8'h00);
    send_request(CMD_READ, 8'h00);
    send_request(CMD_READ, 8'h00);
    send_request(CMD_READ, 8'h00);
    wait_drained();

    // tight limits: walk through a full stop and resume turn
    write_limits(LIMIT_W'(2), LIMIT_W'(1));
    send_request(CMD_WRITE, 8'h5A);
    send_request(CMD_WRITE, 8'h3C);
    send_request(CMD_WRITE, 8'hC3);
    send_request(CMD_WRITE, 8'h81);
    send_request(CMD_STOP_ACK, 8'h00);
    send_request(CMD_STOP_ACK, 8'h00);
    send_request(CMD_READ, 8'h00);
    send_request(CMD_READ, 8'h00);
    send_request(CMD_READ, 8'h00);
    send_request(CMD_GO_ACK, 8'h00);
    send_request(CMD_READ, 8'h00);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        stop_v   = LIMIT_W'($urandom_range(0, 256));
        resume_v = LIMIT_W'($urandom_range(0, 256));
      end else begin
        stop_v   = LIMIT_W'(phase_stop[ph]);
        resume_v = LIMIT_W'(phase_res[ph]);
      end
      write_limits(stop_v, resume_v);
      sender_eager = (ph == 2 || ph == 5);
      run_phase(phase_len[ph], phase_wr[ph], phase_rd[ph]);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/wmfc_pkg.sv
hdl/wmfc_ram.sv
hdl/wmfc_ctrl.sv
hdl/wmfc_dp.sv
hdl/watermark_flow_control_fifo.sv
test/watermark_flow_control_fifo_tb.sv
